/* rtl/assert_macros.svh */
// Assertion macros shared by the sliding window minimum checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Property that must hold while reset is applied
`define SWM_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk_i) !rst_ni |-> (cons)) else $error(msg);

`endif

/* rtl/swm_pkg.sv */
// Shared types and constants for the sliding window minimum block
package swm_pkg;

  // Width and reset value of the window size register
  localparam int unsigned WinWidth = 5;
  localparam logic [WinWidth-1:0] WinReset = 5'd4;

  // Broadcast control from the top level to every cell of the chain
  typedef struct packed {
    logic                load;     // a sample transaction is taken this cycle
    logic                restart;  // sample starts a new sequence
    logic [WinWidth-1:0] win;      // effective window, 1..min(MAX_WINDOW, 31)
  } swm_ctrl_t;

endpackage

/* rtl/swm_cell.sv */
// One cell of the candidate chain: holds the sample of a fixed age and its live flag
module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned AGE          = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_pkg::swm_ctrl_t             ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           prev_alive_i,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_val_i,
  output logic                           alive_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic                           alive_next_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_next_o
);
  import swm_pkg::*;

  localparam bit IsHead = (AGE == 0);

  logic                           alive_q, alive_d;
  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic                           keep;

  // A candidate survives the shift unless it expires, a restart wipes it,
  // or the new sample is not larger than it. The head always holds the new sample.
  always_comb begin
    if (IsHead) begin
      keep = 1'b1;
    end else begin
      keep = prev_alive_i && !ctrl_i.restart && (prev_val_i < sample_i) &&
             (AGE < int'(ctrl_i.win));
    end
    alive_d = ctrl_i.load ? keep       : alive_q;
    val_d   = ctrl_i.load ? prev_val_i : val_q;
  end

  // Live flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else begin
      alive_q <= alive_d;
    end
  end

  // Sample value
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign alive_o      = alive_q;
  assign val_o        = val_q;
  assign alive_next_o = alive_d;
  assign val_next_o   = val_d;

endmodule

/* rtl/swm_tree.sv */
// Pipelined select tree that picks the oldest live candidate of the chain
module swm_tree #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned MAX_WINDOW   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           leaf_alive_i [MAX_WINDOW],
  input  logic signed [SAMPLE_WIDTH-1:0] leaf_val_i [MAX_WINDOW],
  input  logic                           push_i,
  output logic                           ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] min_o
);

  localparam int unsigned Levels = $clog2(MAX_WINDOW);
  localparam int unsigned Leaves = 1 << Levels;

  logic [Leaves-1:0]              pad_alive;
  logic signed [SAMPLE_WIDTH-1:0] pad_val [Leaves];

  // Heap-ordered nodes: node k has children 2k (younger) and 2k+1 (older)
  logic                           node_alive_q [1:Leaves-1];
  logic signed [SAMPLE_WIDTH-1:0] node_val_q   [1:Leaves-1];

  // Level 0 is the root, level Levels-1 takes the leaves
  logic [Levels-1:0] lvl_vld_q, lvl_vld_d;
  logic [Levels-1:0] lvl_en;

  // Pad the leaf row up to a power of two with dead entries
  for (genvar i = 0; i < Leaves; i++) begin : g_pad
    if (i < MAX_WINDOW) begin : g_real
      assign pad_alive[i] = leaf_alive_i[i];
      assign pad_val[i]   = leaf_val_i[i];
    end else begin : g_dead
      assign pad_alive[i] = 1'b0;
      assign pad_val[i]   = '0;
    end
  end

  // Each level moves when it is empty or the level closer to the output moves
  always_comb begin
    lvl_en[0] = !lvl_vld_q[0] || out_ready_i;
    for (int l = 1; l < Levels; l++) begin
      lvl_en[l] = !lvl_vld_q[l] || lvl_en[l-1];
    end
  end

  assign lvl_vld_d = Levels'({push_i, lvl_vld_q} >> 1);

  // Level valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= '0;
    end else begin
      for (int l = 0; l < Levels; l++) begin
        if (lvl_en[l]) begin
          lvl_vld_q[l] <= lvl_vld_d[l];
        end
      end
    end
  end

  // Select nodes: the older child wins when it is live
  for (genvar k = 1; k < Leaves; k++) begin : g_node
    localparam int unsigned Lvl = $clog2(k + 1) - 1;

    logic                           yng_alive, old_alive;
    logic signed [SAMPLE_WIDTH-1:0] yng_val, old_val;

    if (2 * k >= Leaves) begin : g_leaf
      assign yng_alive = pad_alive[2*k-Leaves];
      assign yng_val   = pad_val[2*k-Leaves];
      assign old_alive = pad_alive[2*k+1-Leaves];
      assign old_val   = pad_val[2*k+1-Leaves];
    end else begin : g_inner
      assign yng_alive = node_alive_q[2*k];
      assign yng_val   = node_val_q[2*k];
      assign old_alive = node_alive_q[2*k+1];
      assign old_val   = node_val_q[2*k+1];
    end

    always_ff @(posedge clk_i) begin
      if (lvl_en[Lvl]) begin
        node_alive_q[k] <= old_alive || yng_alive;
        node_val_q[k]   <= old_alive ? old_val : yng_val;
      end
    end
  end

  assign ready_o     = lvl_en[Levels-1];
  assign out_valid_o = lvl_vld_q[0];
  assign min_o       = node_val_q[1];

endmodule

/* rtl/sliding_window_minimum_top.sv */
// Sliding window minimum: a chain of age-ordered candidate cells and a select tree.
// Each result is registered through every level of the select tree after its sample
// transaction is taken.
// Throughput: one sample per cycle unless the output stalls; the tree levels act as buffer stages under stall.
// Reset: window_size returns to 4, fill count and all candidate flags clear at once.
module sliding_window_minimum_top #(
  parameter int unsigned MAX_WINDOW   = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swm_pkg::WinWidth-1:0]        cfg_window_size_i,
  // sample input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic                                restart_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      window_min_o
);
  import swm_pkg::*;

  localparam int unsigned FillW = $clog2(MAX_WINDOW + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(MAX_WINDOW);
  localparam logic [WinWidth-1:0] WinCap =
    (MAX_WINDOW > 31) ? 5'd31 : WinWidth'(MAX_WINDOW);

  logic [WinWidth-1:0] window_size_q;
  logic [WinWidth-1:0] win_eff;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                in_accept;
  logic                emit;
  logic                tree_ready;
  swm_ctrl_t           cell_ctrl;

  logic                           cell_alive      [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cell_val        [MAX_WINDOW];
  logic                           cell_alive_next [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cell_val_next   [MAX_WINDOW];

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WinReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_size_q <= cfg_window_size_i;
    end
  end

  // Zero means one, anything above the chain length means the whole chain
  always_comb begin
    if (window_size_q == '0) begin
      win_eff = WinWidth'(1);
    end else if (window_size_q > WinCap) begin
      win_eff = WinCap;
    end else begin
      win_eff = window_size_q;
    end
  end

  assign in_ready_o = tree_ready;
  assign in_accept  = in_valid_i && in_ready_o;

  // Samples since restart, saturating at the chain length
  always_comb begin
    if (restart_i) begin
      fill_d = FillW'(1);
    end else if (fill_q == FillMax) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + 1'b1;
    end
  end

  assign emit = (fill_d >= FillW'(win_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_accept) begin
      fill_q <= fill_d;
    end
  end

  assign cell_ctrl = '{load: in_accept, restart: restart_i, win: win_eff};

  // Candidate chain: cell i holds the sample of age i
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                           prev_alive;
    logic signed [SAMPLE_WIDTH-1:0] prev_val;

    if (i == 0) begin : g_head
      assign prev_alive = 1'b1;
      assign prev_val   = sample_i;
    end else begin : g_body
      assign prev_alive = cell_alive[i-1];
      assign prev_val   = cell_val[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE          (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .sample_i     (sample_i),
      .prev_alive_i (prev_alive),
      .prev_val_i   (prev_val),
      .alive_o      (cell_alive[i]),
      .val_o        (cell_val[i]),
      .alive_next_o (cell_alive_next[i]),
      .val_next_o   (cell_val_next[i])
    );
  end

  // Oldest live candidate is the window minimum
  swm_tree #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .leaf_alive_i (cell_alive_next),
    .leaf_val_i   (cell_val_next),
    .push_i       (in_accept && emit),
    .ready_o      (tree_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .min_o        (window_min_o)
  );

endmodule

/* rtl/swm_checker.sv */
// Port-level checker for the sliding window minimum top level, with its bind
module swm_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] window_min_o
);

`include "assert_macros.svh"

  // A stalled result stays offered
  `SWM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped under stall")

  // A stalled result keeps its value
  `SWM_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(window_min_o), "result changed under stall")

  // With the output slot free the pipeline must take a sample
  `SWM_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "input blocked with empty output")

  // No result while reset is applied
  `SWM_ASSERT_RST(a_reset_quiet, !out_valid_o, "result shown during reset")

endmodule

bind sliding_window_minimum_top swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .window_min_o (window_min_o)
);
